[src/km8h_pkg.sv]
// ----------------------------------------------------------------------------
// km8h_pkg
// Shared types and constants for the 8-ary max-heap merge core: heap
// geometry, entry layout, command codes, memory request and sequencer states.
// ----------------------------------------------------------------------------
package km8h_pkg;

	// heap geometry
	localparam int MAX_LISTS = 256;
	localparam int FANOUT    = 8;

	// field widths
	localparam int VAL_W = 31;
	localparam int OWN_W = 8;
	localparam int CMD_W = 2;
	localparam int CNT_W = 9;

	// derived widths: entry index, heap size, child position
	localparam int IDX_W  = $clog2(MAX_LISTS);
	localparam int SIZE_W = $clog2(MAX_LISTS + 1);
	localparam int CH_W   = $clog2(MAX_LISTS * FANOUT + FANOUT + 1);

	// command codes; code 3 is unused and only reports the top
	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD    = 2'd0,
		CMD_BUILD   = 2'd1,
		CMD_REPLACE = 2'd2
	} cmd_t;

	// one heap entry: current head value and the list that owns it
	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [OWN_W-1:0] owner;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// request from the sequencer to the heap memory
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		entry_t           wdata;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

	// sequencer states
	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_KRD    = 8'b0000_0010,
		S_KCAP   = 8'b0000_0100,
		S_SETUP  = 8'b0000_1000,
		S_SCAN   = 8'b0001_0000,
		S_DECIDE = 8'b0010_0000,
		S_PLACE  = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

endpackage

[src/km8h_ram.sv]
// ----------------------------------------------------------------------------
// km8h_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module km8h_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[src/km8h_cmp.sv]
// ----------------------------------------------------------------------------
// km8h_cmp
// Shared value comparator. Serves both the child scan (child against best
// so far) and the sift decision (best child against the key).
// ----------------------------------------------------------------------------
module km8h_cmp (
	input  logic [km8h_pkg::VAL_W-1:0] a,
	input  logic [km8h_pkg::VAL_W-1:0] b,
	output logic                       gt
);

	import km8h_pkg::*;

	// strict greater-than keeps the lowest position on ties
	assign gt = (a > b);

endmodule

[src/km8h_ctrl.sv]
// ----------------------------------------------------------------------------
// km8h_ctrl
// Sequencer of the heap core. Runs load, build and replace commands over the
// heap memory, scanning children one read per cycle through the shared
// comparator and moving the key down one level per pass.
// ----------------------------------------------------------------------------
module km8h_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [km8h_pkg::CMD_W-1:0] command,
	input  logic [km8h_pkg::OWN_W-1:0] list_index,
	input  logic [km8h_pkg::VAL_W-1:0] value,
	input  logic [km8h_pkg::CNT_W-1:0] list_count,
	input  km8h_pkg::entry_t           rdata,
	output km8h_pkg::mem_req_t         mem_req,
	output logic                       busy,
	output logic                       done,
	output km8h_pkg::entry_t           top
);

	import km8h_pkg::*;

	state_t            state_q;
	entry_t            top_q;
	entry_t            key_q;
	entry_t            best_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [IDX_W-1:0]  pos_q;
	logic [IDX_W-1:0]  i_q;
	logic              build_q;
	logic [CH_W-1:0]   rd_q;
	logic [CH_W-1:0]   last_q;
	logic              vld_s1;
	logic              first_s1;
	logic [IDX_W-1:0]  idx_s1;

	logic [SIZE_W-1:0] size;
	logic [CH_W-1:0]   size_ch;
	logic [CH_W-1:0]   first;
	logic [CH_W-1:0]   last_full;
	logic [CH_W-1:0]   last;
	logic [IDX_W-1:0]  build_top;
	logic              accept;
	logic              in_range;
	logic              issue;
	logic              take_child;
	logic              more_build;
	logic [VAL_W-1:0]  cmp_a;
	logic [VAL_W-1:0]  cmp_b;
	logic              gt;

	// heap size: list count saturated at the memory depth
	assign size    = (32'(list_count) > MAX_LISTS) ? SIZE_W'(MAX_LISTS) : SIZE_W'(list_count);
	assign size_ch = CH_W'(size);

	// child range of the current position
	assign first     = CH_W'(pos_q) * CH_W'(FANOUT) + CH_W'(1);
	assign last_full = first + CH_W'(FANOUT - 1);
	assign last      = (last_full >= size_ch) ? (size_ch - CH_W'(1)) : last_full;

	// last internal node, where a build starts
	assign build_top = IDX_W'((size - SIZE_W'(2)) / FANOUT);

	assign accept     = start && (state_q == S_IDLE);
	assign in_range   = (32'(list_index) < MAX_LISTS);
	assign issue      = (state_q == S_SCAN) && (rd_q <= last_q);
	assign more_build = build_q && (i_q != '0);

	// steer the shared comparator
	always_comb begin
		if (state_q == S_DECIDE) begin
			cmp_a = best_q.value;
			cmp_b = key_q.value;
		end else begin
			cmp_a = rdata.value;
			cmp_b = best_q.value;
		end
	end

	km8h_cmp u_cmp (
		.a  (cmp_a),
		.b  (cmp_b),
		.gt (gt)
	);

	assign take_child = vld_s1 && (first_s1 || gt);

	// memory requests
	always_comb begin
		mem_req.we    = 1'b0;
		mem_req.waddr = pos_q;
		mem_req.wdata = key_q;
		mem_req.raddr = pos_q;
		case (state_q)
			S_IDLE: begin
				if (accept && (command == CMD_LOAD) && in_range) begin
					mem_req.we          = 1'b1;
					mem_req.waddr       = IDX_W'(list_index);
					mem_req.wdata.value = value;
					mem_req.wdata.owner = list_index;
				end else if (accept && (command == CMD_REPLACE) && (size < SIZE_W'(2))) begin
					mem_req.we          = 1'b1;
					mem_req.waddr       = '0;
					mem_req.wdata.value = value;
					mem_req.wdata.owner = top_q.owner;
				end
			end
			S_SCAN: begin
				mem_req.raddr = rd_q[IDX_W-1:0];
			end
			S_DECIDE: begin
				mem_req.we    = 1'b1;
				mem_req.wdata = gt ? best_q : key_q;
			end
			S_PLACE: begin
				mem_req.we = 1'b1;
			end
			default: begin
				mem_req.we = 1'b0;
			end
		endcase
	end

	// mirror entry 0 so the top is always at hand
	always_ff @(posedge clk) begin
		if (mem_req.we && (mem_req.waddr == '0)) begin
			top_q <= mem_req.wdata;
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			build_q  <= 1'b0;
			vld_s1   <= 1'b0;
			first_s1 <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd_t'(command))
							CMD_LOAD: begin
								state_q <= S_DONE;
							end
							CMD_BUILD: begin
								if (size < SIZE_W'(2)) begin
									state_q <= S_DONE;
								end else begin
									build_q <= 1'b1;
									state_q <= S_KRD;
								end
							end
							CMD_REPLACE: begin
								build_q <= 1'b0;
								if (size < SIZE_W'(2)) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_SETUP;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_KRD: begin
					state_q <= S_KCAP;
				end
				S_KCAP: begin
					state_q <= S_SETUP;
				end
				S_SETUP: begin
					vld_s1 <= 1'b0;
					if (first >= size_ch) begin
						state_q <= S_PLACE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					vld_s1   <= issue;
					first_s1 <= (rd_q == first);
					if (!issue && !vld_s1) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (gt) begin
						state_q <= S_SETUP;
					end else if (more_build) begin
						state_q <= S_KRD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_PLACE: begin
					if (more_build) begin
						state_q <= S_KRD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept && (command == CMD_BUILD)) begin
					i_q   <= build_top;
					pos_q <= build_top;
				end else if (accept && (command == CMD_REPLACE)) begin
					key_q.value <= value;
					key_q.owner <= top_q.owner;
					pos_q       <= '0;
				end
			end
			S_KCAP: begin
				key_q <= rdata;
			end
			S_SETUP: begin
				rd_q   <= first;
				last_q <= last;
			end
			S_SCAN: begin
				idx_s1 <= rd_q[IDX_W-1:0];
				if (issue) begin
					rd_q <= rd_q + CH_W'(1);
				end
				if (take_child) begin
					best_q     <= rdata;
					best_idx_q <= idx_s1;
				end
			end
			S_DECIDE: begin
				if (gt) begin
					pos_q <= best_idx_q;
				end else if (more_build) begin
					i_q   <= i_q - IDX_W'(1);
					pos_q <= i_q - IDX_W'(1);
				end
			end
			S_PLACE: begin
				if (more_build) begin
					i_q   <= i_q - IDX_W'(1);
					pos_q <= i_q - IDX_W'(1);
				end
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);
	assign top  = top_q;

endmodule

[src/k_way_merge_8ary_max_heap_core.sv]
// ----------------------------------------------------------------------------
// k_way_merge_8ary_max_heap_core
// Selection stage of a descending k-way merge: an 8-ary max-heap of list
// heads held in one RAM, sifted by a sequencer around a shared comparator.
//
//   port group       dir  handshake            word
//   command channel  in   start, busy          command, list_index, value
//   result channel   out  done (one cycle)     top_value, top_list, all_done
//   config write     in   cfg_we               cfg_wdata (list_count)
//
// Load, unused command, and build or replace below two entries go to done.
// Replace: per level, set up the child range, scan the children and decide;
// when the key reaches a leaf it is placed there. Build: per internal node, a
// key read and its sift. Children are read one per cycle through the single
// RAM read port.
// Reset clears the sequencer, list_count is 1; done cannot be stalled.
// ----------------------------------------------------------------------------
module k_way_merge_8ary_max_heap_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [km8h_pkg::CMD_W-1:0] command,
	input  logic [km8h_pkg::OWN_W-1:0] list_index,
	input  logic [km8h_pkg::VAL_W-1:0] value,
	output logic                       done,
	output logic [km8h_pkg::VAL_W-1:0] top_value,
	output logic [km8h_pkg::OWN_W-1:0] top_list,
	output logic                       all_done,
	input  logic                       cfg_we,
	input  logic [km8h_pkg::CNT_W-1:0] cfg_wdata
);

	import km8h_pkg::*;

	logic [CNT_W-1:0] list_count_q;
	mem_req_t         mem_req;
	entry_t           rdata;
	entry_t           top;

	// list count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_count_q <= CNT_W'(1);
		end else if (cfg_we) begin
			list_count_q <= cfg_wdata;
		end
	end

	// heap storage
	km8h_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_LISTS)
	) u_heap_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.raddr (mem_req.raddr),
		.rdata (rdata)
	);

	// command sequencer
	km8h_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.command    (command),
		.list_index (list_index),
		.value      (value),
		.list_count (list_count_q),
		.rdata      (rdata),
		.mem_req    (mem_req),
		.busy       (busy),
		.done       (done),
		.top        (top)
	);

	// report the top entry
	assign top_value = top.value;
	assign top_list  = top.owner;
	assign all_done  = (top.value == '0);

	// a result only follows an accepted word or work in progress
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start || busy))
		else $error("result strobe without a command in progress");

	// an accepted word always starts work
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not make the core busy");

	// one result per word: the strobe is never held high
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

endmodule

[tb/k_way_merge_8ary_max_heap_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_way_merge_8ary_max_heap_core_tb
// Self-checking bench for the 8-ary max-heap merge core. A heap model in a
// small scoreboard class tracks every accepted command word and queues the
// top report it should produce; each done word is checked against the
// oldest report. The stimulus starts with directed corner words, then runs
// merge phases: set list_count, load the list heads, build, and advance the
// top list with descending next elements, mixed with noise words.
// ----------------------------------------------------------------------------
module k_way_merge_8ary_max_heap_core_tb;
	import km8h_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam logic [VAL_W-1:0] VALUE_MAX  = '1;
	localparam int unsigned      ITEM_GOAL  = 1900;

	// one expected top report
	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [OWN_W-1:0] owner;
		logic             empty;
	} top_report_t;

	// heap model plus the queue of top reports still owed by the core
	class merge_heap_model;
		logic [VAL_W-1:0] head_value [MAX_LISTS];
		logic [OWN_W-1:0] head_owner [MAX_LISTS];
		bit               loaded     [MAX_LISTS];
		int unsigned      list_count;
		top_report_t      expected_tops [$];
		int unsigned      mismatches;

		function new();
			list_count = 1;
			mismatches = 0;
			foreach (loaded[i]) begin
				loaded[i]     = 0;
				head_value[i] = '0;
				head_owner[i] = '0;
			end
		endfunction

		function int unsigned heap_size();
			return (list_count > MAX_LISTS) ? MAX_LISTS : list_count;
		endfunction

		// true when every entry the heap can touch has been loaded
		function bit heap_loaded(int unsigned size);
			for (int unsigned i = 0; i < size; i++) begin
				if (!loaded[i])
					return 0;
			end
			return loaded[0];
		endfunction

		// move the key at pos down past any strictly larger child
		function void push_down(int unsigned pos, int unsigned size);
			logic [VAL_W-1:0] held_value;
			logic [OWN_W-1:0] key_owner;
			logic [VAL_W-1:0] best_value;
			int unsigned      first;
			int unsigned      last;
			int unsigned      best;
			bit               moving;
			if (pos >= size)
				return;
			held_value = head_value[pos];
			key_owner  = head_owner[pos];
			moving     = 1;
			while (moving) begin
				first = pos * FANOUT + 1;
				if (first >= size) begin
					moving = 0;
				end else begin
					last = first + FANOUT - 1;
					if (last >= size)
						last = size - 1;
					best       = first;
					best_value = head_value[first];
					// lowest position wins among equal children
					for (int unsigned i = first + 1; i <= last; i++) begin
						if (head_value[i] > best_value) begin
							best       = i;
							best_value = head_value[i];
						end
					end
					if (held_value >= best_value) begin
						moving = 0;
					end else begin
						head_value[pos] = best_value;
						head_owner[pos] = head_owner[best];
						pos             = best;
					end
				end
			end
			head_value[pos] = held_value;
			head_owner[pos] = key_owner;
		endfunction

		function void heapify();
			int unsigned size;
			size = heap_size();
			if (size < 2)
				return;
			for (int i = (size - 2) / FANOUT; i >= 0; i--)
				push_down(i, size);
		endfunction

		// apply an accepted command word and queue the top it should report
		function void note_command(logic [CMD_W-1:0] cmd, logic [OWN_W-1:0] idx,
				logic [VAL_W-1:0] val);
			top_report_t rep;
			case (cmd)
				CMD_LOAD: begin
					head_value[idx] = val;
					head_owner[idx] = idx;
					loaded[idx]     = 1;
				end
				CMD_BUILD: begin
					heapify();
				end
				CMD_REPLACE: begin
					head_value[0] = val;
					push_down(0, heap_size());
				end
				default: begin
				end
			endcase
			rep.value = head_value[0];
			rep.owner = head_owner[0];
			rep.empty = (head_value[0] == '0);
			expected_tops.push_back(rep);
		endfunction

		// compare a done word with the oldest queued top report
		function void check_top(logic [VAL_W-1:0] got_value, logic [OWN_W-1:0] got_list,
				logic got_done);
			top_report_t want;
			if (expected_tops.size() == 0) begin
				mismatches++;
				$display("%0t: result word with nothing expected: top_value %h top_list %h",
					$time, got_value, got_list);
				return;
			end
			want = expected_tops.pop_front();
			if (got_value !== want.value) begin
				mismatches++;
				$display("%0t: top_value mismatch: expected %h, actual %h",
					$time, want.value, got_value);
			end
			if (got_list !== want.owner) begin
				mismatches++;
				$display("%0t: top_list mismatch: expected %h, actual %h",
					$time, want.owner, got_list);
			end
			if (got_done !== want.empty) begin
				mismatches++;
				$display("%0t: all_done mismatch: expected %b, actual %b",
					$time, want.empty, got_done);
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [CMD_W-1:0] command;
	logic [OWN_W-1:0] list_index;
	logic [VAL_W-1:0] value;
	logic             done;
	logic [VAL_W-1:0] top_value;
	logic [OWN_W-1:0] top_list;
	logic             all_done;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	merge_heap_model sb = new();
	int unsigned     items_sent = 0;
	int unsigned     burst_left = 0;

	k_way_merge_8ary_max_heap_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.list_index (list_index),
		.value      (value),
		.done       (done),
		.top_value  (top_value),
		.top_list   (top_list),
		.all_done   (all_done),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// check every done word at the edge that ends it
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_top(top_value, top_list, all_done);
	end

	// hard stop well beyond the slowest correct run
	initial begin
		#100_000_000;
		$display("k_way_merge_8ary_max_heap_core test failed");
		$finish;
	end

	// drive one command word, idling between bursts; note it once accepted
	task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [OWN_W-1:0] idx,
			input logic [VAL_W-1:0] val);
		int unsigned gap;
		bit          accepted;
		if (burst_left == 0) begin
			gap = $urandom_range(8, 1);
			@(negedge clk);
			start      = 1'b0;
			command    = CMD_W'($urandom);
			list_index = OWN_W'($urandom);
			value      = VAL_W'($urandom);
			repeat (gap - 1) @(negedge clk);
			burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(80, 30)
			                                         : $urandom_range(12, 1);
		end
		burst_left--;
		@(negedge clk);
		start      = 1'b1;
		command    = cmd;
		list_index = idx;
		value      = val;
		accepted   = 0;
		while (!accepted) begin
			@(posedge clk);
			accepted = !busy;
		end
		sb.note_command(cmd, idx, val);
		items_sent++;
	endtask

	// hold off the sender until every queued top has been reported
	task automatic pause_sender();
		@(negedge clk);
		start = 1'b0;
		while (sb.expected_tops.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write list_count while the core is idle
	task automatic write_list_count(input int unsigned count);
		pause_sender();
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = CNT_W'(count);
		@(negedge clk);
		cfg_we        = 1'b0;
		sb.list_count = count;
	endtask

	// list head: exhausted, maximum, small (ties) or any value
	function automatic logic [VAL_W-1:0] rand_head();
		case ($urandom_range(7, 0))
			0:       return '0;
			1:       return VALUE_MAX;
			2:       return VAL_W'($urandom_range(4, 0));
			default: return VAL_W'($urandom);
		endcase
	endfunction

	// next element of the top list: never above the current top
	function automatic logic [VAL_W-1:0] next_element();
		int unsigned pick;
		int unsigned top;
		pick = $urandom_range(99, 0);
		top  = sb.head_value[0];
		if (pick < 20)
			return '0;
		else if (pick < 35)
			return VAL_W'(top);
		else
			return VAL_W'($urandom_range(top, 0));
	endfunction

	// one merge: set the list count, load heads, build, advance the top list
	task automatic run_phase(input int unsigned count);
		int unsigned size;
		int unsigned cap;
		int unsigned steps;
		int unsigned pick;
		bit          stop;
		write_list_count(count);
		size = sb.heap_size();
		if (size <= 64 || !sb.heap_loaded(size)) begin
			for (int unsigned i = 0; i < ((size == 0) ? 1 : size); i++)
				send_cmd(CMD_LOAD, OWN_W'(i), rand_head());
		end else begin
			repeat (24) send_cmd(CMD_LOAD, OWN_W'($urandom_range(size - 1, 0)), rand_head());
		end
		send_cmd(CMD_BUILD, OWN_W'($urandom), VAL_W'($urandom));
		cap   = (size > 64) ? $urandom_range(40, 20) : $urandom_range(90, 20);
		steps = 0;
		stop  = 0;
		while (!stop && steps < cap) begin
			if (sb.head_value[0] == '0 && $urandom_range(3, 0) != 0) begin
				stop = 1;
			end else begin
				pick = $urandom_range(99, 0);
				if (pick < 85)
					send_cmd(CMD_REPLACE, OWN_W'($urandom), next_element());
				else if (pick < 89)
					send_cmd(CMD_UNUSED, OWN_W'($urandom), VAL_W'($urandom));
				else if (pick < 93)
					send_cmd(CMD_LOAD, OWN_W'($urandom), rand_head());
				else if (pick < 96)
					send_cmd(CMD_BUILD, OWN_W'($urandom), VAL_W'($urandom));
				else
					send_cmd(CMD_REPLACE, OWN_W'($urandom), VAL_W'($urandom));
				if ($urandom_range(29, 0) == 0)
					pause_sender();
				steps++;
			end
		end
	endtask

	initial begin
		int unsigned phase;
		int unsigned pick;
		int unsigned count;
		logic [VAL_W-1:0] directed_heads [10];

		arst_n     = 1'b0;
		start      = 1'b0;
		command    = '0;
		list_index = '0;
		value      = '0;
		cfg_we     = 1'b0;
		cfg_wdata  = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// single list after reset: load entry 0 before anything reports it
		send_cmd(CMD_LOAD, '0, VALUE_MAX);
		send_cmd(CMD_UNUSED, '1, '1);
		send_cmd(CMD_REPLACE, '1, '0);
		send_cmd(CMD_BUILD, '0, '0);
		send_cmd(CMD_LOAD, '0, VAL_W'(7));
		send_cmd(CMD_REPLACE, '0, VAL_W'(7));

		// two heap levels with tied children and tied maxima
		write_list_count(10);
		directed_heads = '{VAL_W'(3), VAL_W'(9), VAL_W'(9), VAL_W'(0), VALUE_MAX,
		                   VAL_W'(1), VALUE_MAX, VAL_W'(2), VAL_W'(9), VAL_W'(5)};
		for (int i = 0; i < 10; i++)
			send_cmd(CMD_LOAD, OWN_W'(i), directed_heads[i]);
		send_cmd(CMD_BUILD, '0, '0);
		send_cmd(CMD_REPLACE, '0, VALUE_MAX);
		send_cmd(CMD_REPLACE, '0, VAL_W'(9));
		// load after build, outside the heap
		send_cmd(CMD_LOAD, '1, VALUE_MAX);
		send_cmd(CMD_UNUSED, '0, '0);
		send_cmd(CMD_REPLACE, '0, '0);
		send_cmd(CMD_REPLACE, '0, '0);
		send_cmd(CMD_REPLACE, '0, '0);

		// random merge phases; force the list count extremes early
		phase = 0;
		while (items_sent < ITEM_GOAL) begin
			pick = $urandom_range(99, 0);
			if (phase == 0)
				count = MAX_LISTS;
			else if (phase == 1)
				count = 0;
			else if (phase == 2)
				count = (1 << CNT_W) - 1;
			else if (pick < 5)
				count = 0;
			else if (pick < 11)
				count = 1;
			else if (pick < 16)
				count = $urandom_range((1 << CNT_W) - 1, MAX_LISTS);
			else if (pick < 26)
				count = $urandom_range(64, 17);
			else
				count = $urandom_range(16, 2);
			run_phase(count);
			phase++;
		end

		// drain and let the core settle
		@(negedge clk);
		start = 1'b0;
		while (sb.expected_tops.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.mismatches == 0)
			$display("k_way_merge_8ary_max_heap_core test passed");
		else
			$display("k_way_merge_8ary_max_heap_core test failed");
		$finish;
	end

endmodule

[filelist.f]
src/km8h_pkg.sv
src/km8h_ram.sv
src/km8h_cmp.sv
src/km8h_ctrl.sv
src/k_way_merge_8ary_max_heap_core.sv
tb/k_way_merge_8ary_max_heap_core_tb.sv
